@@ rtl/apq_pkg.sv @@
// shared constants, codes and controller/datapath interface types for the priority queue
package apq_pkg;

    localparam int DEPTH    = 8;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 7;
    localparam int ENTRY_W  = DATA_W + PRIO_W;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;     // take the input word
        logic scan_rd;    // read entry at scan index and step it
        logic decide;     // capture result, adjust count, load shift start
        logic shift_rd;   // read entry above the shift index
        logic shift_wr;   // write it one slot down
        logic load_out;   // move pending result into the output register
    } t_apq_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic scan_last;
        logic need_shift;
        logic shift_last;
        logic out_free;
    } t_apq_sts;

endpackage

@@ rtl/array_priority_queue.sv @@
// top level of the stable-maximum priority queue
//
// usage
//   input channel: i_valid / o_stall carry one word (i_kind, i_item_data,
//   i_item_priority); a word is taken at a clock edge with i_valid high and
//   o_stall low. kinds: enqueue, dequeue highest, peek highest.
//   output channel: o_valid / i_stall carry one result word per input word
//   (o_status, o_out_data, o_out_priority, o_fill_count).
// sequence from acceptance to result
//   enqueue, empty or unused kind: straight to result hand-off
//   peek: scan every held entry, then decide; dequeue: as peek, then close
//   the gap above the removed entry; next word taken the cycle after the
//   result is loaded; the single read port of the entry ram sets the pace:
//   the maximum search reads one entry a cycle and closing the gap after a
//   dequeue is a read then a write per moved entry
// reset: synchronous, active low; empties the store and drops any pending
//   result, the entry ram itself is not cleared
// back-pressure: a stalled result holds in the output register while the
//   next word is already taken and worked on; it then waits until the
//   output register frees
module array_priority_queue import apq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [DATA_W-1:0]   i_item_data,
    input  logic [PRIO_W-1:0]   i_item_priority,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_out_data,
    output logic [PRIO_W-1:0]   o_out_priority,
    output logic [FILL_W-1:0]   o_fill_count
);

    t_apq_cmd cmd;
    t_apq_sts sts;

    // sequencer: idle, scan for the maximum, gap closing, result hand-off
    apq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // entry ram in arrival order, oldest at slot zero
    apq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_kind          (i_kind),
        .i_item_data     (i_item_data),
        .i_item_priority (i_item_priority),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_data      (o_out_data),
        .o_out_priority  (o_out_priority),
        .o_fill_count    (o_fill_count)
    );

endmodule

@@ rtl/apq_ram.sv @@
// generic single write port, single read port ram with registered read
module apq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/apq_ctrl.sv @@
// sequencing state machine for the priority queue
module apq_ctrl import apq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_stall,
    input  t_apq_sts          i_sts,
    output t_apq_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if ((i_kind == KIND_DEQ || i_kind == KIND_PEEK) && !i_sts.empty) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_sts.need_shift ? S_SHIFT_RD : S_DONE;
            end
            S_SHIFT_RD: begin
                o_cmd.shift_rd = 1'b1;
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state = i_sts.shift_last ? S_DONE : S_SHIFT_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

@@ rtl/apq_dp.sv @@
// entry store, scan compare, gap closing and result registers of the priority queue
module apq_dp import apq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [DATA_W-1:0]   i_item_data,
    input  logic [PRIO_W-1:0]   i_item_priority,
    input  logic                i_stall,
    input  t_apq_cmd            i_cmd,
    output t_apq_sts            o_sts,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_out_data,
    output logic [PRIO_W-1:0]   o_out_priority,
    output logic [FILL_W-1:0]   o_fill_count
);

    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_idx;
    logic                r_is_deq;
    logic                r_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic [IDX_W-1:0]    r_best_idx;
    logic [PRIO_W-1:0]   r_best_prio;
    logic [DATA_W-1:0]   r_best_data;
    logic [STATUS_W-1:0] r_res_status;
    logic [DATA_W-1:0]   r_res_data;
    logic [PRIO_W-1:0]   r_res_prio;
    logic                r_out_valid;

    logic                full;
    logic                enq_wr;
    logic [CNT_W-1:0]    last_slot;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic [PRIO_W-1:0]   rd_prio;
    logic [DATA_W-1:0]   rd_dat;
    logic                take_best;

    assign full      = (r_count == CNT_W'(DEPTH));
    assign last_slot = r_count - CNT_W'(1);
    assign enq_wr    = i_cmd.accept && (i_kind == KIND_ENQ) && !full;

    assign wr_en   = enq_wr || i_cmd.shift_wr;
    assign wr_addr = i_cmd.accept ? r_count[IDX_W-1:0] : r_idx;
    assign wr_data = i_cmd.accept ? {i_item_priority, i_item_data} : rd_data;
    assign rd_en   = i_cmd.scan_rd || i_cmd.shift_rd;
    assign rd_addr = i_cmd.shift_rd ? (r_idx + IDX_W'(1)) : r_idx;

    apq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_prio = rd_data[ENTRY_W-1:DATA_W];
    assign rd_dat  = rd_data[DATA_W-1:0];

    // strictly greater keeps the oldest of equal priorities
    assign take_best = r_cmp_vld &&
        ((r_cmp_idx == '0) || ($signed(rd_prio) > $signed(r_best_prio)));

    assign o_sts.empty      = (r_count == '0);
    assign o_sts.scan_last  = ({{(CNT_W-IDX_W){1'b0}}, r_idx} == last_slot);
    assign o_sts.need_shift = r_is_deq && ({{(CNT_W-IDX_W){1'b0}}, r_best_idx} != last_slot);
    assign o_sts.shift_last = ({{(CNT_W-IDX_W){1'b0}}, r_idx} == last_slot);
    assign o_sts.out_free   = !r_out_valid || !i_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (enq_wr) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.decide && r_is_deq) begin
                r_count <= last_slot;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and indices
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx      <= '0;
            r_is_deq   <= (i_kind == KIND_DEQ);
            r_res_data <= '0;
            r_res_prio <= '0;
            if (i_kind == KIND_ENQ) begin
                r_res_status <= full ? ST_FULL : ST_OK;
            end else if ((i_kind == KIND_DEQ || i_kind == KIND_PEEK) && (r_count == '0)) begin
                r_res_status <= ST_EMPTY;
            end else begin
                r_res_status <= ST_OK;
            end
        end else if (i_cmd.scan_rd) begin
            if (!o_sts.scan_last) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end else if (i_cmd.decide) begin
            r_idx        <= r_best_idx;
            r_res_status <= ST_OK;
            r_res_prio   <= r_best_prio;
            r_res_data   <= r_is_deq ? r_best_data : '0;
        end else if (i_cmd.shift_wr) begin
            r_idx <= r_idx + IDX_W'(1);
        end

        r_cmp_idx <= r_idx;
        if (take_best) begin
            r_best_idx  <= r_cmp_idx;
            r_best_prio <= rd_prio;
            r_best_data <= rd_dat;
        end

        if (i_cmd.load_out) begin
            o_status       <= r_res_status;
            o_out_data     <= r_res_data;
            o_out_priority <= r_res_prio;
            o_fill_count   <= FILL_W'(r_count);
        end
    end

    assign o_valid = r_out_valid;

endmodule

@@ rtl/apq_checker.sv @@
// port-level checks on the priority queue, bound to the top level
module apq_checker import apq_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [DATA_W-1:0]   o_out_data,
    input logic [PRIO_W-1:0]   o_out_priority,
    input logic [FILL_W-1:0]   o_fill_count
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_out_data)
            && $stable(o_out_priority) && $stable(o_fill_count))
        else $error("stalled result changed");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fill_count <= FILL_W'(DEPTH))
        else $error("fill count beyond depth");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_fill_count == FILL_W'(DEPTH))
        else $error("full reported below depth");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_fill_count == '0 && o_out_data == '0
            && o_out_priority == '0)
        else $error("empty result with entries or data");

endmodule

bind array_priority_queue apq_checker u_apq_checker (.*);
